// File: rtl/multilevel_feedback_queue_scheduler_defines.svh
// assertion macros shared by the checker
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH

`define MFQ_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("check failed");

`define MFQ_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("check failed");

`endif

// File: rtl/mfq_pkg.sv
package mfq_pkg;
	localparam int LEVELS = 8;
	localparam int FIFO_DEPTH = 64;
	localparam int TASK_COUNT = 1024;
	localparam int LVL_W = $clog2(LEVELS);
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int ADDR_W = LVL_W + PTR_W;
	localparam int ID_W = 10;
	localparam int WGT_W = 22;
	localparam logic [WGT_W-1:0] WEIGHT_MAX = '1;
	localparam logic [31:0] SLICE_RESET = 32'd200000000;
	localparam logic [10:0] RATIO_RESET = 11'd307;

	localparam logic [1:0] MODE_PUT = 2'd0;
	localparam logic [1:0] MODE_TAKE = 2'd1;
	localparam logic [1:0] MODE_STATS = 2'd2;

	localparam logic CFG_SLICE = 1'b0;
	localparam logic CFG_RATIO = 1'b1;

	// triangular multiplier (i+1)(i+2)/2 for level i
	function automatic logic [5:0] tri_mult(input logic [LVL_W-1:0] i);
		logic [6:0] n;
		n = 7'(i) + 7'd1;
		tri_mult = 6'((n * (n + 7'd1)) >> 1);
	endfunction
endpackage

// File: rtl/multilevel_feedback_queue_scheduler.sv
// Eight-level feedback queue of task ids. A command is accepted at a rising edge with start
// high and busy low, and runs on one shared 32x22 multiplier under a small sequencer. A put
// walks the levels upward from prior_level with one threshold multiply per level, then
// finishes in ST_DONE. A take visits the levels in turn: it skips each empty level, and on
// each waiting level forms the low and high half of run time times weight, then the compare;
// if a level waits, it reads the chosen level's fifo in ST_READ; it finishes in ST_DONE.
// A stats add passes through ST_STAT and ST_DONE, the unused mode straight to ST_DONE. The
// single result word shows for one cycle on done, in the first cycle with busy low. The
// receiver cannot stall it, so it must take every word as it comes. Writing the ratio
// register recomputes the weights in ST_WGT, keeping the block busy as after reset.
module multilevel_feedback_queue_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  mode,
	input  logic [9:0]  task_id,
	input  logic [47:0] elapsed_ns,
	input  logic [2:0]  prior_level,
	input  logic [2:0]  stat_level,
	input  logic [39:0] exec_time,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic [2:0]  assigned_level,
	output logic        overflow,
	output logic        granted,
	output logic [9:0]  granted_task,
	output logic [2:0]  granted_level,
	output logic [9:0]  total_waiting
);
	localparam int LW = mfq_pkg::LVL_W;
	localparam int PW = mfq_pkg::PTR_W;
	localparam int CW = mfq_pkg::CNT_W;
	localparam int WW = mfq_pkg::WGT_W;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_PUT   = 8'b00000010,
		ST_TAKE  = 8'b00000100,
		ST_TCMP  = 8'b00001000,
		ST_READ  = 8'b00010000,
		ST_STAT  = 8'b00100000,
		ST_DONE  = 8'b01000000,
		ST_WGT   = 8'b10000000
	} state_t;

	state_t state_q;
	logic [31:0] slice_q;
	logic [10:0] ratio_q;
	logic [WW-1:0] wgt_q [mfq_pkg::LEVELS];
	logic [PW-1:0] head_q [mfq_pkg::LEVELS];
	logic [CW-1:0] cnt_q [mfq_pkg::LEVELS];
	logic [63:0] run_q [mfq_pkg::LEVELS];
	logic [9:0] store_q [mfq_pkg::LEVELS * mfq_pkg::FIFO_DEPTH];
	logic [9:0] rd_q;

	logic [1:0] mode_q;
	logic [9:0] id_q;
	logic [47:0] spent_q;
	logic [LW-1:0] lvl_q;
	logic half_q;
	logic [85:0] acc_q;
	logic [85:0] best_q;
	logic found_q;
	logic [LW-1:0] best_lvl_q;
	logic [64:0] sum_q;
	logic [9:0] wait_q;

	// shared multiplier
	logic [31:0] mul_a;
	logic [21:0] mul_b;
	logic [53:0] mul_p;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_PUT: begin
				mul_a = slice_q;
				mul_b = 22'(mfq_pkg::tri_mult(lvl_q));
			end
			ST_TAKE: begin
				mul_a = half_q ? run_q[lvl_q][63:32] : run_q[lvl_q][31:0];
				mul_b = wgt_q[lvl_q];
			end
			ST_WGT: begin
				mul_a = 32'(wgt_q[lvl_q]);
				mul_b = 22'(ratio_q);
			end
			default: ;
		endcase
		mul_p = 54'(mul_a) * 54'(mul_b);
	end

	logic [LW:0] lvl_nx;
	logic [32:0] wnext;
	assign lvl_nx = {1'b0, lvl_q} + (LW+1)'(1);
	assign wnext = mul_p[40:8];

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !start;

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && mode_q == mfq_pkg::MODE_PUT && !overflow)
			store_q[{assigned_level, PW'(head_q[assigned_level] + PW'(cnt_q[assigned_level]))}]
				<= id_q;
		rd_q <= store_q[{best_lvl_q, head_q[best_lvl_q]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WGT;
			slice_q <= mfq_pkg::SLICE_RESET;
			ratio_q <= mfq_pkg::RATIO_RESET;
			for (int i = 0; i < mfq_pkg::LEVELS; i++) begin
				wgt_q[i] <= (i == 0) ? WW'(256) : '0;
				head_q[i] <= '0;
				cnt_q[i] <= '0;
				run_q[i] <= '0;
			end
			mode_q <= '0;
			id_q <= '0;
			spent_q <= '0;
			lvl_q <= '0;
			half_q <= 1'b0;
			acc_q <= '0;
			best_q <= '0;
			found_q <= 1'b0;
			best_lvl_q <= '0;
			sum_q <= '0;
			wait_q <= '0;
			done <= 1'b0;
			assigned_level <= '0;
			overflow <= 1'b0;
			granted <= 1'b0;
			granted_task <= '0;
			granted_level <= '0;
			total_waiting <= '0;
		end else begin
			done <= (state_q == ST_DONE);
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						if (cfg_index == mfq_pkg::CFG_SLICE) begin
							slice_q <= cfg_data;
						end else begin
							ratio_q <= cfg_data[10:0];
							lvl_q <= '0;
							state_q <= ST_WGT;
						end
					end else if (start) begin
						mode_q <= mode;
						id_q <= task_id;
						spent_q <= elapsed_ns;
						half_q <= 1'b0;
						found_q <= 1'b0;
						assigned_level <= '0;
						overflow <= 1'b0;
						granted <= 1'b0;
						granted_task <= '0;
						granted_level <= '0;
						case (mode)
							mfq_pkg::MODE_PUT: begin
								lvl_q <= prior_level;
								state_q <= ST_PUT;
							end
							mfq_pkg::MODE_TAKE: begin
								lvl_q <= '0;
								state_q <= ST_TAKE;
							end
							mfq_pkg::MODE_STATS: begin
								sum_q <= {1'b0, run_q[stat_level]} + 65'(exec_time);
								lvl_q <= stat_level;
								state_q <= ST_STAT;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_WGT: begin
					wgt_q[lvl_nx[LW-1:0]] <= (wnext > 33'(mfq_pkg::WEIGHT_MAX)) ?
						mfq_pkg::WEIGHT_MAX : wnext[WW-1:0];
					if (lvl_nx == (LW+1)'(mfq_pkg::LEVELS - 1)) begin
						lvl_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						lvl_q <= lvl_nx[LW-1:0];
					end
				end
				ST_PUT: begin
					if ({6'd0, spent_q} < mul_p || lvl_q == LW'(mfq_pkg::LEVELS - 1)) begin
						assigned_level <= lvl_q;
						overflow <= (cnt_q[lvl_q] == CW'(mfq_pkg::FIFO_DEPTH));
						state_q <= ST_DONE;
					end else begin
						lvl_q <= lvl_nx[LW-1:0];
					end
				end
				ST_TAKE: begin
					if (cnt_q[lvl_q] == '0) begin
						if (lvl_q == LW'(mfq_pkg::LEVELS - 1))
							state_q <= found_q ? ST_READ : ST_DONE;
						else
							lvl_q <= lvl_nx[LW-1:0];
					end else if (!half_q) begin
						acc_q <= 86'(mul_p);
						half_q <= 1'b1;
					end else begin
						acc_q <= acc_q + {mul_p, 32'd0};
						half_q <= 1'b0;
						state_q <= ST_TCMP;
					end
				end
				ST_TCMP: begin
					if (!found_q || acc_q < best_q) begin
						best_q <= acc_q;
						best_lvl_q <= lvl_q;
						found_q <= 1'b1;
					end
					if (lvl_q == LW'(mfq_pkg::LEVELS - 1)) begin
						state_q <= ST_READ;
					end else begin
						lvl_q <= lvl_nx[LW-1:0];
						state_q <= ST_TAKE;
					end
				end
				ST_READ: begin
					// rd_q is a registered read of the chosen head, so the grant waits until half_q is set
					if (half_q) begin
						granted <= 1'b1;
						granted_task <= rd_q;
						granted_level <= best_lvl_q;
						head_q[best_lvl_q] <= head_q[best_lvl_q] + PW'(1);
						cnt_q[best_lvl_q] <= cnt_q[best_lvl_q] - CW'(1);
						wait_q <= wait_q - 10'd1;
						half_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						half_q <= 1'b1;
					end
				end
				ST_STAT: begin
					run_q[lvl_q] <= sum_q[64] ? '1 : sum_q[63:0];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (mode_q == mfq_pkg::MODE_PUT && !overflow) begin
						cnt_q[assigned_level] <= cnt_q[assigned_level] + CW'(1);
						total_waiting <= wait_q + 10'd1;
						wait_q <= wait_q + 10'd1;
					end else begin
						total_waiting <= wait_q;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/mfq_checker.sv
`include "multilevel_feedback_queue_scheduler_defines.svh"
module mfq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       cfg_ready,
	input logic       overflow,
	input logic       granted,
	input logic [9:0] total_waiting
);
	`MFQ_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`MFQ_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`MFQ_ASSERT_IMP(a_done_excl, clk, arst_n, done, !(overflow && granted))
	`MFQ_ASSERT_IMP(a_cfg_idle, clk, arst_n, cfg_ready, !busy)
	`MFQ_ASSERT_IMP(a_wait_max, clk, arst_n, done, total_waiting <= 10'd512)
endmodule

bind multilevel_feedback_queue_scheduler mfq_checker u_mfq_checker (.*);

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
	localparam logic [1:0] MODE_IDLE = 2'd3;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [1:0]  mode;
		logic [9:0]  id;
		logic [47:0] spent;
		logic [2:0]  prior;
		logic [2:0]  slvl;
		logic [39:0] ex;
	} sched_cmd_t;

	typedef struct packed {
		logic [2:0] lvl;
		logic       ovf;
		logic       gr;
		logic [9:0] gtask;
		logic [2:0] glvl;
		logic [9:0] waiting;
	} sched_word_t;

	typedef struct {
		sched_cmd_t  cmd;
		bit          known;
		sched_word_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy, done;
	logic [1:0]  mode = MODE_IDLE;
	logic [9:0]  task_id = '0;
	logic [47:0] elapsed_ns = '0;
	logic [2:0]  prior_level = '0;
	logic [2:0]  stat_level = '0;
	logic [39:0] exec_time = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = mfq_pkg::CFG_SLICE;
	logic [31:0] cfg_data = '0;
	logic [2:0]  assigned_level;
	logic        overflow, granted;
	logic [9:0]  granted_task;
	logic [2:0]  granted_level;
	logic [9:0]  total_waiting;

	multilevel_feedback_queue_scheduler dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the scheduler
	logic [31:0] cfg_slice;
	logic [10:0] cfg_ratio;
	logic [9:0]  lvl_mem [mfq_pkg::LEVELS][mfq_pkg::FIFO_DEPTH];
	int          lvl_head [mfq_pkg::LEVELS];
	int          lvl_count [mfq_pkg::LEVELS];
	logic [63:0] lvl_runtime [mfq_pkg::LEVELS];
	logic [21:0] lvl_weight [mfq_pkg::LEVELS];

	sched_word_t pending_words[$];
	int          fail_count = 0;
	int          cycles = 0;
	bit          idle_on = 1'b1;

	task automatic build_weights();
		logic [63:0] w;
		w = 64'd256;
		for (int i = 0; i < mfq_pkg::LEVELS; i++) begin
			lvl_weight[i] = w[21:0];
			w = (w * cfg_ratio) >> 8;
			if (w > 64'(mfq_pkg::WEIGHT_MAX))
				w = 64'(mfq_pkg::WEIGHT_MAX);
		end
	endtask

	task automatic schedule_step(input sched_cmd_t c, output sched_word_t r);
		int          best;
		int          lv;
		int          sum;
		logic [85:0] prod, best_prod;
		logic [63:0] thr;
		logic [64:0] acc;
		r = '0;
		best_prod = '0;
		case (c.mode)
			mfq_pkg::MODE_PUT: begin
				lv = mfq_pkg::LEVELS - 1;
				for (int i = int'(c.prior); i < mfq_pkg::LEVELS; i++) begin
					thr = 64'(cfg_slice) * 64'((i + 1) * (i + 2) / 2);
					if (64'(c.spent) < thr) begin
						lv = i;
						break;
					end
				end
				r.lvl = 3'(lv);
				if (lvl_count[lv] >= mfq_pkg::FIFO_DEPTH)
					r.ovf = 1'b1;
				else begin
					lvl_mem[lv][(lvl_head[lv] + lvl_count[lv]) % mfq_pkg::FIFO_DEPTH] = c.id;
					lvl_count[lv]++;
				end
			end
			mfq_pkg::MODE_TAKE: begin
				best = -1;
				for (int i = 0; i < mfq_pkg::LEVELS; i++) begin
					if (lvl_count[i] == 0)
						continue;
					prod = 86'(lvl_runtime[i]) * 86'(lvl_weight[i]);
					if (best < 0 || prod < best_prod) begin
						best = i;
						best_prod = prod;
					end
				end
				if (best >= 0) begin
					r.gr = 1'b1;
					r.gtask = lvl_mem[best][lvl_head[best]];
					r.glvl = 3'(best);
					lvl_head[best] = (lvl_head[best] + 1) % mfq_pkg::FIFO_DEPTH;
					lvl_count[best]--;
				end
			end
			mfq_pkg::MODE_STATS: begin
				acc = 65'(lvl_runtime[c.slvl]) + 65'(c.ex);
				lvl_runtime[c.slvl] = acc[64] ? '1 : acc[63:0];
			end
			default: ;
		endcase
		sum = 0;
		for (int i = 0; i < mfq_pkg::LEVELS; i++)
			sum += lvl_count[i];
		r.waiting = 10'(sum);
	endtask

	task automatic chk(input string name, input logic [9:0] want, input logic [9:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		sched_word_t w;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				w = pending_words.pop_front();
				chk("assigned_level", 10'(w.lvl), 10'(assigned_level));
				chk("overflow", 10'(w.ovf), 10'(overflow));
				chk("granted", 10'(w.gr), 10'(granted));
				chk("granted_task", w.gtask, granted_task);
				chk("granted_level", 10'(w.glvl), 10'(granted_level));
				chk("total_waiting", w.waiting, total_waiting);
			end
		end
	end

	task automatic issue(input sched_cmd_t c, input bit known, input sched_word_t want);
		sched_word_t r;
		if (idle_on && $urandom_range(99) < 28) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		mode <= c.mode;
		task_id <= c.id;
		elapsed_ns <= c.spent;
		prior_level <= c.prior;
		stat_level <= c.slvl;
		exec_time <= c.ex;
		do @(posedge clk); while (busy);
		schedule_step(c, r);
		pending_words.push_back(known ? want : r);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == mfq_pkg::CFG_SLICE)
			cfg_slice = val;
		else begin
			cfg_ratio = val[10:0];
			build_weights();
		end
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	function automatic sched_cmd_t rand_cmd(input int kind, input int lvl);
		sched_cmd_t c;
		int k, t;
		c.id = 10'($urandom);
		c.prior = 3'($urandom);
		c.slvl = 3'($urandom);
		c.ex = ($urandom_range(3) == 0) ? '1 : {8'($urandom), 32'($urandom)};
		k = $urandom_range(5);
		if (k == 0)
			c.spent = '0;
		else if (k == 1)
			c.spent = '1;
		else if (k == 2)
			c.spent = {16'($urandom), 32'($urandom)};
		else begin
			t = $urandom_range(mfq_pkg::LEVELS - 1);
			c.spent = 48'(64'(cfg_slice) * 64'((t + 1) * (t + 2) / 2) + 64'($urandom_range(2))
				- 64'd1);
		end
		k = $urandom_range(99);
		case (kind)
			0: begin
				// fill one level toward overflow
				c.mode = (k < 90) ? mfq_pkg::MODE_PUT : mfq_pkg::MODE_TAKE;
				if (k < 80) begin
					c.prior = 3'(lvl);
					c.spent = '0;
				end
			end
			1: c.mode = (k < 75) ? mfq_pkg::MODE_TAKE :
				(k < 90 ? mfq_pkg::MODE_STATS : mfq_pkg::MODE_PUT);
			default: c.mode = (k < 40) ? mfq_pkg::MODE_PUT : (k < 70 ? mfq_pkg::MODE_TAKE :
				(k < 95 ? mfq_pkg::MODE_STATS : MODE_IDLE));
		endcase
		return c;
	endfunction

	initial begin
		dir_row_t    dir_tab[$];
		sched_word_t none;
		int          kind, lvl, left;
		logic [31:0] slices [6];
		logic [31:0] ratios [6];

		none = '0;
		cfg_slice = mfq_pkg::SLICE_RESET;
		cfg_ratio = mfq_pkg::RATIO_RESET;
		build_weights();
		for (int i = 0; i < mfq_pkg::LEVELS; i++) begin
			lvl_head[i] = 0;
			lvl_count[i] = 0;
			lvl_runtime[i] = '0;
		end

		dir_tab.push_back('{'{mfq_pkg::MODE_TAKE, 10'd3, 48'd0, 3'd0, 3'd0, 40'd0}, 1, '0});
		dir_tab.push_back('{'{MODE_IDLE, '1, '1, 3'd7, 3'd7, '1}, 1, '0});
		dir_tab.push_back('{'{mfq_pkg::MODE_PUT, 10'd1023, 48'd0, 3'd0, 3'd0, 40'd0}, 1,
			'{3'd0, 1'b0, 1'b0, 10'd0, 3'd0, 10'd1}});
		dir_tab.push_back('{'{mfq_pkg::MODE_PUT, 10'd0, '1, 3'd0, 3'd0, 40'd0}, 1,
			'{3'd7, 1'b0, 1'b0, 10'd0, 3'd0, 10'd2}});
		dir_tab.push_back('{'{mfq_pkg::MODE_PUT, 10'd5, 48'd0, 3'd7, 3'd0, 40'd0}, 1,
			'{3'd7, 1'b0, 1'b0, 10'd0, 3'd0, 10'd3}});
		dir_tab.push_back('{'{mfq_pkg::MODE_PUT, 10'd6, 48'd199999999, 3'd0, 3'd0, 40'd0}, 1,
			'{3'd0, 1'b0, 1'b0, 10'd0, 3'd0, 10'd4}});
		dir_tab.push_back('{'{mfq_pkg::MODE_PUT, 10'd7, 48'd200000000, 3'd0, 3'd0, 40'd0}, 1,
			'{3'd1, 1'b0, 1'b0, 10'd0, 3'd0, 10'd5}});
		dir_tab.push_back('{'{mfq_pkg::MODE_PUT, 10'd8, 48'd600000000, 3'd1, 3'd0, 40'd0}, 0,
			none});
		dir_tab.push_back('{'{mfq_pkg::MODE_STATS, 10'd0, 48'd0, 3'd0, 3'd0, '1}, 0, none});
		dir_tab.push_back('{'{mfq_pkg::MODE_STATS, 10'd0, 48'd0, 3'd0, 3'd7, 40'd0}, 0, none});
		dir_tab.push_back('{'{mfq_pkg::MODE_STATS, 10'd0, 48'd0, 3'd0, 3'd1, 40'd1000}, 0,
			none});
		for (int i = 0; i < 8; i++)
			dir_tab.push_back('{'{mfq_pkg::MODE_TAKE, 10'd0, 48'd0, 3'd0, 3'd0, 40'd0}, 0,
				none});
		dir_tab.push_back('{'{mfq_pkg::MODE_STATS, '1, '1, 3'd7, 3'd3, 40'd1}, 0, none});

		slices = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1000, 32'd50, 32'd200000000};
		ratios = '{32'd256, 32'd1024, 32'd307, 32'd2047, 32'd0, 32'd512};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (!cfg_ready)
			@(posedge clk);
		@(posedge clk);

		foreach (dir_tab[i])
			issue(dir_tab[i].cmd, dir_tab[i].known, dir_tab[i].want);

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			if (ph < 6) begin
				write_reg(mfq_pkg::CFG_SLICE, slices[ph]);
				write_reg(mfq_pkg::CFG_RATIO, ratios[ph]);
			end else begin
				write_reg(mfq_pkg::CFG_SLICE, $urandom_range(1, 5000));
				write_reg(mfq_pkg::CFG_RATIO, $urandom_range(256, 1024));
			end
			// one phase runs with no gaps at all
			idle_on = (ph != 3);
			left = 170;
			while (left > 0) begin
				kind = $urandom_range(2);
				lvl = $urandom_range(mfq_pkg::LEVELS - 1);
				for (int n = $urandom_range(10, 80); n > 0 && left > 0; n--) begin
					issue(rand_cmd(kind, lvl), 0, none);
					left--;
				end
			end
		end

		drain();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
